/* src/fir_pkg.sv */
package fir_pkg;

	localparam int MAX_TAPS = 64;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int TAP_CNT_W = 7;
	localparam int COEF_IDX_W = 6;

	localparam int ADDR_W = $clog2(MAX_TAPS);
	localparam int CNT_W  = $clog2(MAX_TAPS + 1);
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W  = PROD_W + ADDR_W + 1;
	localparam int SHIFT  = COEF_W - 1;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (SHIFT - 1);

	// request command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctrl_t;

endpackage

/* src/fir_ram.sv */
module fir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/fir_mac.sv */
module fir_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fir_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [fir_pkg::COEF_W-1:0]   coef,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] smp,
	output logic                                done,
	output logic signed [fir_pkg::SAMPLE_W-1:0] result
);

	localparam int RW = fir_pkg::ACC_W - fir_pkg::SHIFT;

	logic signed [fir_pkg::PROD_W-1:0] prod_s2;
	fir_pkg::mac_ctrl_t                ctrl_s2;
	logic signed [fir_pkg::ACC_W-1:0]  acc_q;
	logic                              done_q;
	logic signed [fir_pkg::ACC_W-1:0]  acc_base;
	logic signed [RW-1:0]              shr;
	logic [RW-fir_pkg::SAMPLE_W:0]     top_bits;

	always_ff @(posedge clk) begin
		prod_s2 <= coef * smp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl;
			done_q  <= ctrl_s2.vld & ctrl_s2.last;
		end
	end

	// rounding half is folded in with the first product
	assign acc_base = ctrl_s2.first ? fir_pkg::ROUND_HALF : acc_q;

	always_ff @(posedge clk) begin
		if (ctrl_s2.vld) begin
			acc_q <= acc_base + fir_pkg::ACC_W'(prod_s2);
		end
	end

	assign shr      = acc_q[fir_pkg::ACC_W-1:fir_pkg::SHIFT];
	assign top_bits = shr[RW-1:fir_pkg::SAMPLE_W-1];

	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			result = shr[fir_pkg::SAMPLE_W-1:0];
		end else if (shr[RW-1]) begin
			result = {1'b1, {(fir_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(fir_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

	assign done = done_q;

endmodule

/* src/fir_filter_stream_core.sv */
// Streaming FIR filter, Q1.15 samples and coefficients. A request with command 0 writes one
// coefficient into the table; a request with command 1 pushes one sample into a circular
// window. Once tap_count samples have arrived since the last block start, each sample
// produces one result: the sum of coef[j] times window sample j (oldest paired with coef 0),
// rounded to nearest (ties up) and saturated to Q1.15. A sample that yields a result is worked
// by the single multiply-accumulate that walks the coefficient and window RAMs one tap per
// cycle; no other request is taken until its result is registered. The coefficient table
// reads as zero until written. The user must write tap_count only while the block is idle;
// the block itself does not enforce this. Zero acts as one tap and values above 64 act as 64.
module fir_filter_stream_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fir_pkg::TAP_CNT_W-1:0]       cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [fir_pkg::COEF_IDX_W-1:0]      coef_index,
	input  logic signed [fir_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] sample,
	input  logic                                start_block,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fir_pkg::SAMPLE_W-1:0] filtered
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_HOLD} state_t;

	state_t                               state_q;
	logic [fir_pkg::TAP_CNT_W-1:0]        tap_count_q;
	logic [fir_pkg::CNT_W-1:0]            fill_q;
	logic [fir_pkg::CNT_W-1:0]            t_q;
	logic [fir_pkg::ADDR_W-1:0]           wptr_q;
	logic [fir_pkg::ADDR_W-1:0]           base_q;
	logic [fir_pkg::ADDR_W-1:0]           j_q;
	logic [fir_pkg::MAX_TAPS-1:0]         coef_vld_q;
	logic                                 coef_vld_s1;
	fir_pkg::mac_ctrl_t                   ctrl_s1;
	fir_pkg::mac_ctrl_t                   ctrl_nxt;
	logic                                 out_valid_q;
	logic signed [fir_pkg::SAMPLE_W-1:0]  filtered_q;

	logic                                 accept;
	logic                                 is_load;
	logic                                 is_sample;
	logic                                 idx_ok;
	logic [fir_pkg::ADDR_W-1:0]           coef_waddr;
	logic [fir_pkg::CNT_W-1:0]            taps;
	logic [fir_pkg::CNT_W-1:0]            fill_base;
	logic [fir_pkg::CNT_W-1:0]            fill_nxt;
	logic                                 want_result;
	logic                                 last_tap;
	logic                                 slot_free;
	logic                                 mac_done;
	logic signed [fir_pkg::SAMPLE_W-1:0]  mac_result;
	logic                                 load_out;
	logic [fir_pkg::COEF_W-1:0]           coef_rd;
	logic [fir_pkg::SAMPLE_W-1:0]         win_rd;
	logic signed [fir_pkg::COEF_W-1:0]    coef_eff;
	logic [fir_pkg::ADDR_W-1:0]           win_raddr;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign is_load   = accept && (command == fir_pkg::CMD_LOAD);
	assign is_sample = accept && (command == fir_pkg::CMD_SAMPLE);

	assign idx_ok     = 32'(coef_index) < fir_pkg::MAX_TAPS;
	assign coef_waddr = fir_pkg::ADDR_W'(coef_index);

	always_comb begin
		if (tap_count_q == '0) begin
			taps = fir_pkg::CNT_W'(1);
		end else if (32'(tap_count_q) > fir_pkg::MAX_TAPS) begin
			taps = fir_pkg::CNT_W'(fir_pkg::MAX_TAPS);
		end else begin
			taps = fir_pkg::CNT_W'(tap_count_q);
		end
	end

	assign fill_base   = start_block ? '0 : fill_q;
	assign fill_nxt    = (32'(fill_base) < fir_pkg::MAX_TAPS) ? fill_base + 1'b1 : fill_base;
	assign want_result = fill_nxt >= taps;

	assign last_tap  = (j_q == fir_pkg::ADDR_W'(t_q - 1'b1));
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = ((state_q == ST_DRAIN && mac_done) || state_q == ST_HOLD) && slot_free;
	assign win_raddr = base_q + j_q;

	always_comb begin
		ctrl_nxt = '0;
		if (state_q == ST_RUN) begin
			ctrl_nxt.vld   = 1'b1;
			ctrl_nxt.first = (j_q == '0);
			ctrl_nxt.last  = last_tap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fir_pkg::TAP_CNT_W'(16);
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			wptr_q      <= '0;
			t_q         <= '0;
			base_q      <= '0;
			j_q         <= '0;
			coef_vld_q  <= '0;
			coef_vld_s1 <= 1'b0;
			ctrl_s1     <= '0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
		end else begin
			ctrl_s1     <= ctrl_nxt;
			coef_vld_s1 <= coef_vld_q[j_q];
			if (is_load && idx_ok) begin
				coef_vld_q[coef_waddr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				filtered_q  <= mac_result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_sample) begin
						wptr_q <= wptr_q + 1'b1;
						fill_q <= fill_nxt;
						if (want_result) begin
							t_q     <= taps;
							// oldest sample of the window sits taps-1 slots behind the newest
							base_q  <= wptr_q - fir_pkg::ADDR_W'(taps - 1'b1);
							j_q     <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= slot_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	fir_ram #(
		.WIDTH(fir_pkg::COEF_W),
		.DEPTH(fir_pkg::MAX_TAPS)
	) u_coef_ram (
		.clk  (clk),
		.we   (is_load && idx_ok),
		.waddr(coef_waddr),
		.wdata(coef_value),
		.raddr(j_q),
		.rdata(coef_rd)
	);

	fir_ram #(
		.WIDTH(fir_pkg::SAMPLE_W),
		.DEPTH(fir_pkg::MAX_TAPS)
	) u_win_ram (
		.clk  (clk),
		.we   (is_sample),
		.waddr(wptr_q),
		.wdata(sample),
		.raddr(win_raddr),
		.rdata(win_rd)
	);

	// unwritten coefficients read as zero
	assign coef_eff = coef_vld_s1 ? $signed(coef_rd) : '0;

	fir_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl_s1),
		.coef  (coef_eff),
		.smp   ($signed(win_rd)),
		.done  (mac_done),
		.result(mac_result)
	);

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule
